[src/max_heap_priority_queue_assert.svh]
// Assertion macros for the max-heap priority queue.
// Needs clk and rst_n in the scope of each use.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, off during reset
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mhpq_pkg.sv]
// Shared types and constants for the max-heap priority queue.
// No dependencies.
package mhpq_pkg;

  localparam int VAL_W        = 32;
  localparam int OUT_CNT_W    = 7;
  localparam int CAPACITY_DEF = 64;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [0:0] {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_POP_RD,
    S_POP_LD,
    S_SINK_RD,
    S_SINK_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic stop;
    logic take_right;
  } cmp_res_t;

endpackage

[src/mhpq_cmp.sv]
// Shared compare unit: parent check on swim, larger-child pick and check on sink.
// Depends on mhpq_pkg.
module mhpq_cmp (
  input  logic              sink_mode,
  input  logic              right_ok,
  input  mhpq_pkg::val_t    hold,
  input  mhpq_pkg::val_t    rd0,
  input  mhpq_pkg::val_t    rd1,
  output mhpq_pkg::cmp_res_t res,
  output mhpq_pkg::val_t    big
);

  logic take_right;

  assign take_right = sink_mode && right_ok && (rd0 < rd1);
  assign big        = take_right ? rd1 : rd0;

  always_comb begin
    res.take_right = take_right;
    // swim: stop when parent >= moving value; sink: stop when moving value >= child
    res.stop       = sink_mode ? (hold >= big) : (rd0 >= hold);
  end

endmodule

[src/max_heap_priority_queue.sv]
// Top level of the max-heap priority queue: sequencer, heap memory, result regs.
// Depends on mhpq_pkg, mhpq_cmp and max_heap_priority_queue_assert.svh.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  input   | in_req_type, in_value                   | start && !busy
//  result  | out_popped_value, out_top_value,        | out_valid, one cycle
//          | out_count, out_is_empty, out_status     |
//
// A beat is taken when start is high and busy is low; busy stays high until the
// result strobe has been shown. Each swim or sink level has a read state, then a
// compare-and-write state. Push swims up to the root or until a parent stops it;
// pop sinks the last entry from the root to a leaf or until a child stops it, and
// skips the sink on the last entry; moves <= log2(CAPACITY). A full push or an
// empty pop goes straight to S_DONE. Synchronous reset empties the heap; no stalls.
`include "max_heap_priority_queue_assert.svh"

module max_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_req_type,
  input  logic signed [mhpq_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  output logic signed [mhpq_pkg::VAL_W-1:0] out_popped_value,
  output logic signed [mhpq_pkg::VAL_W-1:0] out_top_value,
  output logic [mhpq_pkg::OUT_CNT_W-1:0]    out_count,
  output logic                              out_is_empty,
  output logic [1:0]                        out_status
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY + 2);
  localparam int DEPTH = CAPACITY + 2;

  mhpq_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  mhpq_pkg::val_t     hold_r, hold_nxt;
  mhpq_pkg::val_t     top_r;
  mhpq_pkg::val_t     popped_r;
  mhpq_pkg::status_t  status_r;

  mhpq_pkg::val_t     heap_mem [0:DEPTH-1];
  mhpq_pkg::val_t     rd0_r, rd1_r;
  logic [AW-1:0]      raddr0, raddr1, waddr;
  mhpq_pkg::val_t     wdata;
  logic               we;

  logic               accept;
  logic               is_pop;
  logic               full;
  logic [AW:0]        child;
  logic               no_child;
  logic               right_ok;
  logic [AW-1:0]      parent;
  mhpq_pkg::cmp_res_t cmp_res;
  mhpq_pkg::val_t     cmp_big;

  assign accept   = start && !busy;
  assign is_pop   = (in_req_type == mhpq_pkg::REQ_POP);
  assign full     = (count_r == CW'(CAPACITY));
  assign child    = {pos_r, 1'b0};
  assign no_child = (child > (AW+1)'(count_r));
  assign right_ok = (child < (AW+1)'(count_r));
  assign parent   = pos_r >> 1;

  mhpq_cmp u_cmp (
    .sink_mode (state_r == mhpq_pkg::S_SINK_CMP),
    .right_ok  (right_ok),
    .hold      (hold_r),
    .rd0       (rd0_r),
    .rd1       (rd1_r),
    .res       (cmp_res),
    .big       (cmp_big)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          if (is_pop) state_nxt = (count_r == '0) ? mhpq_pkg::S_DONE : mhpq_pkg::S_POP_RD;
          else        state_nxt = full ? mhpq_pkg::S_DONE : mhpq_pkg::S_PUSH_RD;
        end
      end
      mhpq_pkg::S_PUSH_RD: begin
        state_nxt = (pos_r == AW'(1)) ? mhpq_pkg::S_DONE : mhpq_pkg::S_PUSH_CMP;
      end
      mhpq_pkg::S_PUSH_CMP: begin
        state_nxt = cmp_res.stop ? mhpq_pkg::S_DONE : mhpq_pkg::S_PUSH_RD;
      end
      mhpq_pkg::S_POP_RD: state_nxt = mhpq_pkg::S_POP_LD;
      mhpq_pkg::S_POP_LD: begin
        state_nxt = (count_r == CW'(1)) ? mhpq_pkg::S_DONE : mhpq_pkg::S_SINK_RD;
      end
      mhpq_pkg::S_SINK_RD: begin
        state_nxt = no_child ? mhpq_pkg::S_DONE : mhpq_pkg::S_SINK_CMP;
      end
      mhpq_pkg::S_SINK_CMP: begin
        state_nxt = cmp_res.stop ? mhpq_pkg::S_DONE : mhpq_pkg::S_SINK_RD;
      end
      mhpq_pkg::S_DONE: state_nxt = mhpq_pkg::S_IDLE;
      default:          state_nxt = mhpq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    hold_nxt  = hold_r;
    raddr0    = parent;
    raddr1    = parent;
    waddr     = pos_r;
    wdata     = hold_r;
    we        = 1'b0;
    unique case (state_r)
      mhpq_pkg::S_IDLE: begin
        if (accept && !is_pop && !full) begin
          count_nxt = count_r + 1'b1;
          pos_nxt   = AW'(count_r) + 1'b1;
          hold_nxt  = in_value;
        end
      end
      mhpq_pkg::S_PUSH_RD: begin
        raddr0 = parent;
        we     = (pos_r == AW'(1));
      end
      mhpq_pkg::S_PUSH_CMP: begin
        we = 1'b1;
        if (!cmp_res.stop) begin
          wdata   = rd0_r;
          pos_nxt = parent;
        end
      end
      mhpq_pkg::S_POP_RD: begin
        raddr0 = AW'(count_r);
      end
      mhpq_pkg::S_POP_LD: begin
        hold_nxt  = rd0_r;
        count_nxt = count_r - 1'b1;
        pos_nxt   = AW'(1);
      end
      mhpq_pkg::S_SINK_RD: begin
        raddr0 = child[AW-1:0];
        raddr1 = child[AW-1:0] + 1'b1;
        we     = no_child;
      end
      mhpq_pkg::S_SINK_CMP: begin
        we = 1'b1;
        if (!cmp_res.stop) begin
          wdata   = cmp_big;
          pos_nxt = cmp_res.take_right ? (child[AW-1:0] + 1'b1) : child[AW-1:0];
        end
      end
      mhpq_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    busy             = (state_r != mhpq_pkg::S_IDLE);
    out_valid        = (state_r == mhpq_pkg::S_DONE);
    out_popped_value = popped_r;
    out_top_value    = (count_r == '0) ? '0 : top_r;
    out_count        = mhpq_pkg::OUT_CNT_W'(count_r);
    out_is_empty     = (count_r == '0);
    out_status       = status_r;
  end

  always_ff @(posedge clk) begin
    if (we) heap_mem[waddr] <= wdata;
    rd0_r <= heap_mem[raddr0];
    rd1_r <= heap_mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhpq_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    hold_r <= hold_nxt;
    if (we && waddr == AW'(1)) top_r <= wdata;
    if (accept) begin
      popped_r <= (is_pop && count_r != '0) ? top_r : '0;
      if (is_pop)    status_r <= (count_r == '0) ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_OK;
      else if (full) status_r <= mhpq_pkg::ST_FULL;
      else           status_r <= mhpq_pkg::ST_OK;
    end
  end

  `MHPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(CAPACITY), "count above capacity")
  `MHPQ_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid && !busy, "strobe longer than a cycle")
  `MHPQ_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted beat did not raise busy")
  `MHPQ_ASSERT_NOW(a_full_count, out_valid && out_status == mhpq_pkg::ST_FULL,
    count_r == CW'(CAPACITY), "full status while not full")

endmodule

[test/mhpq_checker.sv]
// Result checker for max_heap_priority_queue: mirrors the heap, predicts each report.
// Depends on mhpq_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 1ps

module mhpq_checker #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              in_req_type,
  input  logic signed [mhpq_pkg::VAL_W-1:0] in_value,
  input  logic                              out_valid,
  input  logic signed [mhpq_pkg::VAL_W-1:0] out_popped_value,
  input  logic signed [mhpq_pkg::VAL_W-1:0] out_top_value,
  input  logic [mhpq_pkg::OUT_CNT_W-1:0]    out_count,
  input  logic                              out_is_empty,
  input  logic [1:0]                        out_status,
  output int                                fail_count,
  output int                                reports_due
);
  import mhpq_pkg::*;

  typedef struct packed {
    val_t                 popped;
    val_t                 top;
    logic [OUT_CNT_W-1:0] cnt;
    logic                 empty;
    status_t              st;
  } heap_report_t;

  val_t         heap_mem [1:CAPACITY];
  int unsigned  n_entries;
  heap_report_t due_reports[$];

  function automatic heap_report_t heap_apply(req_t op, val_t v);
    heap_report_t r;
    int unsigned  pos;
    int unsigned  up;
    int unsigned  c;
    val_t         t;
    bit           done;
    r.popped = '0;
    r.st     = ST_OK;
    if (op == REQ_PUSH) begin
      if (n_entries >= CAPACITY) begin
        r.st = ST_FULL;
      end else begin
        n_entries++;
        heap_mem[n_entries] = v;
        pos  = n_entries;
        done = 0;
        while (pos > 1 && !done) begin
          up = pos / 2;
          if (heap_mem[up] >= heap_mem[pos]) begin
            done = 1;
          end else begin
            t             = heap_mem[up];
            heap_mem[up]  = heap_mem[pos];
            heap_mem[pos] = t;
            pos           = up;
          end
        end
      end
    end else begin
      if (n_entries == 0) begin
        r.st = ST_EMPTY;
      end else begin
        r.popped    = heap_mem[1];
        heap_mem[1] = heap_mem[n_entries];
        n_entries--;
        pos  = 1;
        done = 0;
        while (2 * pos <= n_entries && !done) begin
          c = 2 * pos;
          if (c < n_entries && heap_mem[c] < heap_mem[c + 1]) c++;
          if (heap_mem[pos] >= heap_mem[c]) begin
            done = 1;
          end else begin
            t             = heap_mem[pos];
            heap_mem[pos] = heap_mem[c];
            heap_mem[c]   = t;
            pos           = c;
          end
        end
      end
    end
    r.top   = (n_entries > 0) ? heap_mem[1] : '0;
    r.cnt   = n_entries[OUT_CNT_W-1:0];
    r.empty = (n_entries == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    heap_report_t exp_r;
    if (!rst_n) begin
      n_entries  = 0;
      fail_count = 0;
      due_reports.delete();
    end else begin
      if (out_valid) begin
        if (due_reports.size() == 0) begin
          $error("result beat with no report due");
          fail_count++;
        end else begin
          exp_r = due_reports.pop_front();
          if (out_popped_value !== exp_r.popped) begin
            $error("out_popped_value expected %0d got %0d", exp_r.popped, out_popped_value);
            fail_count++;
          end
          if (out_top_value !== exp_r.top) begin
            $error("out_top_value expected %0d got %0d", exp_r.top, out_top_value);
            fail_count++;
          end
          if (out_count !== exp_r.cnt) begin
            $error("out_count expected %0d got %0d", exp_r.cnt, out_count);
            fail_count++;
          end
          if (out_is_empty !== exp_r.empty) begin
            $error("out_is_empty expected %0d got %0d", exp_r.empty, out_is_empty);
            fail_count++;
          end
          if (out_status !== exp_r.st) begin
            $error("out_status expected %0d got %0d", exp_r.st, out_status);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        due_reports.push_back(heap_apply(req_t'(in_req_type), in_value));
      end
    end
    reports_due = due_reports.size();
  end

endmodule

[test/tb_top.sv]
// Testbench top for max_heap_priority_queue: clock, reset, directed and random beats.
// Depends on mhpq_pkg, the block and mhpq_checker, which predicts and compares.
`timescale 1ns / 1ps

module tb_top;
  import mhpq_pkg::*;

  localparam int CAP        = 64;
  localparam int RAND_BEATS = 1700;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_req_type;
  val_t                  in_value;
  logic                  out_valid;
  val_t                  out_popped_value;
  val_t                  out_top_value;
  logic [OUT_CNT_W-1:0]  out_count;
  logic                  out_is_empty;
  logic [1:0]            out_status;
  int                    fail_count;
  int                    reports_due;

  max_heap_priority_queue #(.CAPACITY(CAP)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_top_value    (out_top_value),
    .out_count        (out_count),
    .out_is_empty     (out_is_empty),
    .out_status       (out_status)
  );

  mhpq_checker #(.CAPACITY(CAP)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_top_value    (out_top_value),
    .out_count        (out_count),
    .out_is_empty     (out_is_empty),
    .out_status       (out_status),
    .fail_count       (fail_count),
    .reports_due      (reports_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("max_heap_priority_queue verification failed");
    $finish;
  end

  bit no_gaps;

  // one beat: optional idle cycles, then hold start until the block takes it
  task automatic send_beat(req_t op, val_t v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    in_req_type <= op;
    in_value    <= v;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic val_t pick_value();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return '0;
          default: return -1;
        endcase
      end
      1, 2: return val_t'($signed($urandom_range(0, 16)) - 8);
      default: return val_t'($urandom());
    endcase
  endfunction

  initial begin
    int seg_len;
    int mode;
    int push_pct;
    int sent;
    req_t op;
    start       = 1'b0;
    in_req_type = 1'b0;
    in_value    = '0;
    no_gaps     = 0;
    rst_n       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, extremes, ties, drain past empty
    send_beat(REQ_POP,  32'sh1234_5678);
    send_beat(REQ_PUSH, 32'sh0000_0000);
    send_beat(REQ_PUSH, 32'sh7FFF_FFFF);
    send_beat(REQ_PUSH, 32'sh8000_0000);
    send_beat(REQ_PUSH, -1);
    send_beat(REQ_PUSH, 1);
    send_beat(REQ_PUSH, 32'sh7FFF_FFFF);
    send_beat(REQ_PUSH, 5);
    send_beat(REQ_PUSH, 5);
    send_beat(REQ_PUSH, 32'shFFFF_FFFF);
    send_beat(REQ_POP,  32'sh7FFF_FFFF);
    send_beat(REQ_POP,  32'sh8000_0000);
    send_beat(REQ_PUSH, 32'sh5555_5555);
    send_beat(REQ_PUSH, 32'shAAAA_AAAA);
    repeat (10) send_beat(REQ_POP, '0);
    send_beat(REQ_POP, -1);

    // random: segments that fill, drain or hover, some without idle cycles
    sent = 0;
    mode = 0;
    while (sent < RAND_BEATS) begin
      seg_len  = (sent == 0) ? 120 : $urandom_range(40, 120);
      push_pct = (mode == 0) ? 90 : (mode == 1) ? 10 : 50;
      no_gaps  = ($urandom_range(0, 3) == 0);
      repeat (seg_len) begin
        op = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
        send_beat(op, pick_value());
        sent++;
      end
      mode = $urandom_range(0, 2);
    end
    @(negedge clk);
    start <= 1'b0;

    while (reports_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && reports_due == 0) begin
      $display("max_heap_priority_queue verification clean");
    end else begin
      $display("max_heap_priority_queue verification failed");
    end
    $finish;
  end

endmodule
